>>> rtl/core/positional_list_store_core_defines.svh
// ----------------------------------------------------------------------------
// positional list store assertion macros
// Shared property shapes for the port checker.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_CORE_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define PLS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// Command, status and sequencer codes plus field widths for the list store.
// ----------------------------------------------------------------------------
package pls_pkg;

   localparam int VALUE_W = 32;
   localparam int POS_W   = 8;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;

   // command codes of an input item
   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_DUMP   = 2'd2,
      CMD_CLEAR  = 2'd3
   } pls_cmd_type;

   // status codes of a result item
   typedef enum logic [STAT_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_EMPTY  = 2'd1,
      STAT_BADPOS = 2'd2,
      STAT_FULL   = 2'd3
   } pls_status_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RM_READ,
      ST_SHIFT,
      ST_RM_DONE,
      ST_DUMP
   } pls_state_type;

endpackage

>>> rtl/core/positional_list_store_core.sv
// ----------------------------------------------------------------------------
// positional_list_store_core: insert, clear and rejected commands load their result in ST_EXEC,
// entered after acceptance; remove at position p reads in ST_EXEC, ST_RM_READ and ST_SHIFT, one shift
// per entry ahead of it, then loads in ST_RM_DONE; dump loads count results one per cycle unless
// the result is stalled; one item at a time. Sync reset empties the list; entries are not cleared.
// ----------------------------------------------------------------------------
module positional_list_store_core
   import pls_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // input channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [CMD_W-1:0]         req_command,
   input  logic signed [VALUE_W-1:0] req_new_value,
   input  logic [POS_W-1:0]         req_position,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [VALUE_W-1:0] rsp_value,
   output logic [POS_W-1:0]         rsp_order,
   output logic [STAT_W-1:0]        rsp_status,
   output logic                     rsp_last,
   output logic [POS_W-1:0]         rsp_count
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW = CW + 1;

   // entries are held back to front: physical index count-1 is the front
   logic signed [VALUE_W-1:0] mem [DEPTH];
   logic                      mem_we;
   logic [AW-1:0]             mem_waddr;
   logic signed [VALUE_W-1:0] mem_wdata;
   logic                      mem_re;
   logic [AW-1:0]             mem_raddr;
   logic signed [VALUE_W-1:0] rdata_ff;

   pls_state_type             state_ff, state_in;
   pls_cmd_type               cmd_ff, cmd_in;
   logic signed [VALUE_W-1:0] nv_ff, nv_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [AW-1:0]             ptr_ff, ptr_in;
   logic [CW-1:0]             ord_ff, ord_in;
   logic signed [VALUE_W-1:0] hold_ff, hold_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [POS_W-1:0]          rsp_order_ff, rsp_order_in;
   pls_status_type            rsp_status_ff, rsp_status_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic [CW-1:0]             rsp_count_ff, rsp_count_in;

   logic                      req_take;
   logic                      out_free;
   logic                      out_load;
   logic                      list_full;
   logic                      pos_bad;
   logic [PW-1:0]             cnt_w;
   logic [PW-1:0]             ptr_p1;
   logic [PW-1:0]             ptr_p2;
   logic [AW-1:0]             rm_phys;
   logic                      dump_end;

   // handshake
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // decode helpers
   assign cnt_w     = PW'(cnt_ff);
   assign ptr_p1    = PW'(ptr_ff) + PW'(1);
   assign ptr_p2    = PW'(ptr_ff) + PW'(2);
   assign list_full = (cnt_ff == CW'(DEPTH));
   assign pos_bad   = (pos_ff == '0) || ({1'b0, pos_ff} > 9'(cnt_ff));
   assign rm_phys   = AW'(cnt_ff - CW'(pos_ff));
   assign dump_end  = (ord_ff == cnt_ff);

   // sequencer: next state, memory port control and result loading
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      nv_in         = nv_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      ptr_in        = ptr_ff;
      ord_in        = ord_ff;
      hold_in       = hold_ff;
      mem_we        = 1'b0;
      mem_waddr     = ptr_ff;
      mem_wdata     = rdata_ff;
      mem_re        = 1'b0;
      mem_raddr     = ptr_ff;
      out_load      = 1'b0;
      rsp_value_in  = '0;
      rsp_order_in  = '0;
      rsp_status_in = STAT_OK;
      rsp_last_in   = 1'b1;
      rsp_count_in  = cnt_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cmd_in   = pls_cmd_type'(req_command);
               nv_in    = req_new_value;
               pos_in   = req_position;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            case (cmd_ff)
               CMD_INSERT: begin
                  if (out_free) begin
                     out_load = 1'b1;
                     state_in = ST_IDLE;
                     if (list_full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        mem_we       = 1'b1;
                        mem_waddr    = AW'(cnt_ff);
                        mem_wdata    = nv_ff;
                        cnt_in       = cnt_ff + CW'(1);
                        rsp_count_in = cnt_ff + CW'(1);
                     end
                  end
               end
               CMD_REMOVE: begin
                  if (cnt_ff == '0 || pos_bad) begin
                     if (out_free) begin
                        out_load      = 1'b1;
                        rsp_status_in = (cnt_ff == '0) ? STAT_EMPTY : STAT_BADPOS;
                        state_in      = ST_IDLE;
                     end
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = rm_phys;
                     ptr_in    = rm_phys;
                     state_in  = ST_RM_READ;
                  end
               end
               CMD_DUMP: begin
                  if (cnt_ff == '0) begin
                     if (out_free) begin
                        out_load      = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                        state_in      = ST_IDLE;
                     end
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = AW'(cnt_ff - CW'(1));
                     ptr_in    = AW'(cnt_ff - CW'(1));
                     ord_in    = CW'(1);
                     state_in  = ST_DUMP;
                  end
               end
               CMD_CLEAR: begin
                  if (out_free) begin
                     out_load     = 1'b1;
                     cnt_in       = '0;
                     rsp_count_in = '0;
                     state_in     = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         // removed value arrives; start pulling the upper entries down
         ST_RM_READ: begin
            hold_in = rdata_ff;
            if (ptr_p1 < cnt_w) begin
               mem_re    = 1'b1;
               mem_raddr = AW'(ptr_p1);
               state_in  = ST_SHIFT;
            end else begin
               state_in = ST_RM_DONE;
            end
         end

         // one entry moves down per cycle, reads run one slot ahead of writes
         ST_SHIFT: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = rdata_ff;
            if (ptr_p2 < cnt_w) begin
               mem_re    = 1'b1;
               mem_raddr = AW'(ptr_p2);
               ptr_in    = AW'(ptr_p1);
            end else begin
               state_in = ST_RM_DONE;
            end
         end

         ST_RM_DONE: begin
            if (out_free) begin
               out_load     = 1'b1;
               rsp_value_in = hold_ff;
               rsp_order_in = pos_ff;
               cnt_in       = cnt_ff - CW'(1);
               rsp_count_in = cnt_ff - CW'(1);
               state_in     = ST_IDLE;
            end
         end

         // one entry per result, front first, next read issued as each one leaves
         ST_DUMP: begin
            if (out_free) begin
               out_load     = 1'b1;
               rsp_value_in = rdata_ff;
               rsp_order_in = POS_W'(ord_ff);
               rsp_last_in  = dump_end;
               if (dump_end) begin
                  state_in = ST_IDLE;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = ptr_ff - AW'(1);
                  ptr_in    = ptr_ff - AW'(1);
                  ord_in    = ord_ff + CW'(1);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   // entry memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item and working registers
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      nv_ff   <= nv_in;
      pos_ff  <= pos_in;
      ptr_ff  <= ptr_in;
      ord_ff  <= ord_in;
      hold_ff <= hold_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_order_ff  <= rsp_order_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_order  = rsp_order_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_count  = POS_W'(rsp_count_ff);

endmodule

>>> rtl/core/pls_checker.sv
// ----------------------------------------------------------------------------
// pls_checker
// Port-level checks for the list store, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "positional_list_store_core_defines.svh"

module pls_checker
   import pls_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic [CMD_W-1:0]          req_command,
   input logic signed [VALUE_W-1:0] req_new_value,
   input logic [POS_W-1:0]          req_position,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic signed [VALUE_W-1:0] rsp_value,
   input logic [POS_W-1:0]          rsp_order,
   input logic [STAT_W-1:0]         rsp_status,
   input logic                      rsp_last,
   input logic [POS_W-1:0]          rsp_count
);

   // a stalled request item stays offered and unchanged
   `PLS_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req_command) && $stable(req_new_value) && $stable(req_position), "request changed while stalled")

   // a stalled result stays offered
   `PLS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")

   // an error or full status is always a single closing item with no value
   `PLS_ASSERT_NOW(a_err_shape, rsp_valid && (rsp_status != STAT_OK), rsp_last && (rsp_value == '0) && (rsp_order == '0), "bad error item")

   // the list never reports more entries than it can hold
   `PLS_ASSERT_NOW(a_count_bound, rsp_valid, rsp_count <= POS_W'(DEPTH), "count above depth")

   // a dump item that is not the last lies inside the list
   `PLS_ASSERT_NOW(a_dump_order, rsp_valid && !rsp_last, (rsp_order != '0) && (rsp_order < rsp_count), "dump order out of range")

endmodule

bind positional_list_store_core pls_checker #(.DEPTH(DEPTH)) u_pls_checker (.*);
